// ===== design/slecm_pkg.sv =====
package slecm_pkg;

    localparam int LINE_CAPACITY = 29;
    localparam int LEN_W         = $clog2(LINE_CAPACITY + 1);
    localparam int CMD_LEN       = 3;
    localparam int CMD_IDX_W     = $clog2(CMD_LEN);

    // line break followed by the version banner, sent back to back
    localparam int MSG_LEN   = 29;
    localparam int MSG_IDX_W = $clog2(MSG_LEN);
    localparam int CRLF_LEN  = 2;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    localparam logic [7:0] CH_BS = 8'h08;
    localparam logic [7:0] CH_CR = 8'h0D;
    localparam logic [7:0] CH_SP = 8'h20;

    localparam logic [6:0] CMD_LOWER [0:CMD_LEN-1] = '{7'h76, 7'h65, 7'h72};
    localparam logic [6:0] CMD_UPPER [0:CMD_LEN-1] = '{7'h56, 7'h45, 7'h52};

    typedef enum logic [1:0] {
        KIND_ECHO,
        KIND_CRLF,
        KIND_VERSION
    } kind_t;

    typedef struct packed {
        kind_t      kind;
        logic [6:0] chr;
    } cmd_t;

    function automatic logic [6:0] msg_byte(input logic [MSG_IDX_W-1:0] idx);
        logic [6:0] b;
        case (idx)
            5'd0:    b = 7'h0D;
            5'd1:    b = 7'h0A;
            5'd2:    b = 7'h0D;
            5'd3:    b = 7'h0A;
            5'd4:    b = 7'h53;
            5'd5:    b = 7'h6F;
            5'd6:    b = 7'h66;
            5'd7:    b = 7'h74;
            5'd8:    b = 7'h77;
            5'd9:    b = 7'h61;
            5'd10:   b = 7'h72;
            5'd11:   b = 7'h65;
            5'd12:   b = 7'h20;
            5'd13:   b = 7'h56;
            5'd14:   b = 7'h65;
            5'd15:   b = 7'h72;
            5'd16:   b = 7'h73;
            5'd17:   b = 7'h69;
            5'd18:   b = 7'h6F;
            5'd19:   b = 7'h6E;
            5'd20:   b = 7'h20;
            5'd21:   b = 7'h31;
            5'd22:   b = 7'h2E;
            5'd23:   b = 7'h30;
            5'd24:   b = 7'h30;
            5'd25:   b = 7'h0D;
            5'd26:   b = 7'h0A;
            5'd27:   b = 7'h0D;
            5'd28:   b = 7'h0A;
            default: b = 7'h00;
        endcase
        return b;
    endfunction

endpackage

// ===== design/serial_line_editor_command_match_core.sv =====
// Console line editor. Each received byte is accepted and edited into the line:
// printable bytes (0x20..0x7F) are echoed while the line holds fewer than 29
// characters, a backspace on a non-empty line is echoed, a carriage return answers
// CR LF and, when the line was exactly "ver" or "VER", the 27-byte version banner
// after it. Zero, high bytes and other control bytes give no output. The result
// sequencer sends one byte per cycle while the output is ready, from a four-entry
// command queue, so input is taken every cycle until that queue fills, as during a
// long banner or an output stall; tlast marks the final byte of each input byte's reply.
module serial_line_editor_command_match_core (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] rx_byte
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [6:0] tx_byte, [7] zero
    output logic       m_axis_tlast    // last_of_run
);
    import slecm_pkg::*;

    logic full, push, pop, head_valid, rx_accept;
    cmd_t push_cmd, head_cmd;

    assign s_axis_tready = !full;
    assign rx_accept     = s_axis_tvalid && s_axis_tready;

    slecm_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .rx_accept (rx_accept),
        .rx_byte   (s_axis_tdata),
        .push      (push),
        .push_cmd  (push_cmd)
    );

    slecm_fifo u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_cmd   (push_cmd),
        .full       (full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_cmd   (head_cmd)
    );

    slecm_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .head_valid    (head_valid),
        .head_cmd      (head_cmd),
        .pop           (pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

// ===== design/slecm_front.sv =====
module slecm_front (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 rx_accept,
    input  logic [7:0]           rx_byte,
    output logic                 push,
    output slecm_pkg::cmd_t      push_cmd
);
    import slecm_pkg::*;

    logic [LEN_W-1:0] line_len_reg, line_len_next;
    // only the leading characters can ever take part in a command match
    logic [6:0]       line_head_reg [0:CMD_LEN-1];
    logic             head_we;
    logic             is_lower, is_upper;

    always_comb begin
        is_lower = (line_len_reg == LEN_W'(CMD_LEN));
        is_upper = (line_len_reg == LEN_W'(CMD_LEN));
        for (int i = 0; i < CMD_LEN; i++) begin
            if (line_head_reg[i] != CMD_LOWER[i]) is_lower = 1'b0;
            if (line_head_reg[i] != CMD_UPPER[i]) is_upper = 1'b0;
        end
    end

    always_comb begin
        line_len_next = line_len_reg;
        push          = 1'b0;
        push_cmd.kind = KIND_ECHO;
        push_cmd.chr  = rx_byte[6:0];
        head_we       = 1'b0;
        if (rx_accept && rx_byte != 8'h00 && !rx_byte[7]) begin
            if (rx_byte == CH_BS) begin
                if (line_len_reg != '0) begin
                    line_len_next = line_len_reg - LEN_W'(1);
                    push          = 1'b1;
                end
            end else if (rx_byte >= CH_SP) begin
                if (line_len_reg < LEN_W'(LINE_CAPACITY)) begin
                    line_len_next = line_len_reg + LEN_W'(1);
                    push          = 1'b1;
                    head_we       = (line_len_reg < LEN_W'(CMD_LEN));
                end
            end else if (rx_byte == CH_CR) begin
                line_len_next = '0;
                push          = 1'b1;
                push_cmd.kind = (is_lower || is_upper) ? KIND_VERSION : KIND_CRLF;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            line_len_reg <= '0;
        end else begin
            line_len_reg <= line_len_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (head_we) begin
            line_head_reg[line_len_reg[CMD_IDX_W-1:0]] <= rx_byte[6:0];
        end
    end

endmodule

// ===== design/slecm_fifo.sv =====
module slecm_fifo (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  slecm_pkg::cmd_t push_cmd,
    output logic            full,
    input  logic            pop,
    output logic            head_valid,
    output slecm_pkg::cmd_t head_cmd
);
    import slecm_pkg::*;

    cmd_t                  entry_reg [0:FIFO_DEPTH-1];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [FIFO_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [FIFO_CNT_W-1:0] count_reg, count_next;
    logic                  do_pop;

    assign full       = (count_reg == FIFO_CNT_W'(FIFO_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_cmd   = entry_reg[rd_ptr_reg];
    assign do_pop     = pop && head_valid;

    always_comb begin
        wr_ptr_next = push   ? wr_ptr_reg + FIFO_PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + FIFO_PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !do_pop) begin
            count_next = count_reg + FIFO_CNT_W'(1);
        end else if (!push && do_pop) begin
            count_next = count_reg - FIFO_CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ===== design/slecm_back.sv =====
module slecm_back (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            head_valid,
    input  slecm_pkg::cmd_t head_cmd,
    output logic            pop,
    output logic            m_axis_tvalid,
    input  logic            m_axis_tready,
    output logic [7:0]      m_axis_tdata,
    output logic            m_axis_tlast
);
    import slecm_pkg::*;

    logic                 active_reg, active_next;
    cmd_t                 cur_cmd_reg, cur_cmd_next;
    logic [MSG_IDX_W-1:0] idx_reg, idx_next;
    logic                 out_valid_reg, out_valid_next;
    logic [6:0]           out_byte_reg, out_byte_next;
    logic                 out_last_reg, out_last_next;

    cmd_t                 cur_cmd;
    logic [MSG_IDX_W-1:0] cur_idx;
    logic                 cur_valid, load, cur_last;

    // a command in progress takes priority over the queue head
    assign cur_valid = active_reg || head_valid;
    assign cur_cmd   = active_reg ? cur_cmd_reg : head_cmd;
    assign cur_idx   = active_reg ? idx_reg : '0;
    assign load      = cur_valid && (!out_valid_reg || m_axis_tready);
    assign pop       = load && !active_reg;

    always_comb begin
        case (cur_cmd.kind)
            KIND_ECHO:    cur_last = 1'b1;
            KIND_CRLF:    cur_last = (cur_idx == MSG_IDX_W'(CRLF_LEN - 1));
            KIND_VERSION: cur_last = (cur_idx == MSG_IDX_W'(MSG_LEN - 1));
            default:      cur_last = 1'b1;
        endcase
    end

    always_comb begin
        active_next    = active_reg;
        cur_cmd_next   = cur_cmd_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        out_byte_next  = out_byte_reg;
        out_last_next  = out_last_reg;
        if (load) begin
            out_valid_next = 1'b1;
            out_byte_next  = (cur_cmd.kind == KIND_ECHO) ? cur_cmd.chr : msg_byte(cur_idx);
            out_last_next  = cur_last;
            active_next    = !cur_last;
            cur_cmd_next   = cur_cmd;
            idx_next       = cur_idx + MSG_IDX_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            active_reg    <= active_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cur_cmd_reg  <= cur_cmd_next;
        idx_reg      <= idx_next;
        out_byte_reg <= out_byte_next;
        out_last_reg <= out_last_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {1'b0, out_byte_reg};
    assign m_axis_tlast  = out_last_reg;

endmodule
